@@ sv/assert_macros.svh @@
// Assertion macros shared by the deframer modules.
// Under SYNTHESIS every macro expands to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define WSD_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("deframer assertion failed")

`define WSD_ASSERT_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("deframer assertion failed")

`else

`define WSD_ASSERT_IMPLY(lbl, clk, rst, ante, cons)

`define WSD_ASSERT_NEVER(lbl, clk, rst, cond)

`endif

`endif

@@ sv/wsd_pkg.sv @@
// ----------------------------------------------------------------------------
// wsd_pkg
// Types and constants shared by the WebSocket frame deframer modules.
// ----------------------------------------------------------------------------
package wsd_pkg;

  localparam int LengthBitsDefault = 64;

  // Seven-bit length codes that announce an extended length.
  localparam logic [6:0] LEN_CODE_16 = 7'd126;
  localparam logic [6:0] LEN_CODE_64 = 7'd127;

  // Work queue between parser and output stage.
  localparam int QueueDepth = 2;
  localparam int QPTR_W     = $clog2(QueueDepth);
  localparam int QCNT_W     = $clog2(QueueDepth + 1);

  // One classified word on its way to the output stage.
  typedef struct packed {
    logic [7:0] data;
    logic [7:0] key;
    logic       byte_valid;
    logic       frame_end;
    logic       fin;
    logic [3:0] opcode;
    logic       error;
  } entry_t;

endpackage

@@ sv/websocket_frame_deframer.sv @@
// Path: an accepted payload word is written into the queue, then registered at the output.
// Throughput: one stream word per cycle unless stalled; the parser takes one header or
// payload word each cycle and the output stage unmasks one queued word each cycle.
// Reset: synchronous and active high; it returns the parser to the first header
// word, clears the halt after a protocol error, and empties queue and output.
// ----------------------------------------------------------------------------
// websocket_frame_deframer
// WebSocket frame decoder: parses headers word by word and emits unmasked
// payload words with frame and message end marks.
// ----------------------------------------------------------------------------
module websocket_frame_deframer #(
  parameter int LENGTH_BITS = wsd_pkg::LengthBitsDefault
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] stream_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] payload_byte,
  output logic       byte_valid,
  output logic [3:0] frame_opcode,
  output logic       final_fragment,
  output logic       frame_end,
  output logic       message_end,
  output logic       protocol_error
);
  import wsd_pkg::*;

  logic   push;
  logic   pop;
  logic   queue_full;
  logic   queue_not_empty;
  entry_t push_entry;
  entry_t head;

  wsd_front #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .stream_byte(stream_byte),
    .queue_full (queue_full),
    .push       (push),
    .entry      (push_entry)
  );

  wsd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_entry(push_entry),
    .full      (queue_full),
    .not_empty (queue_not_empty),
    .pop       (pop),
    .head      (head)
  );

  wsd_back u_back (
    .clk           (clk),
    .rst           (rst),
    .not_empty     (queue_not_empty),
    .head          (head),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .payload_byte  (payload_byte),
    .byte_valid    (byte_valid),
    .frame_opcode  (frame_opcode),
    .final_fragment(final_fragment),
    .frame_end     (frame_end),
    .message_end   (message_end),
    .protocol_error(protocol_error)
  );

endmodule

@@ sv/wsd_front.sv @@
// ----------------------------------------------------------------------------
// wsd_front
// Header parser: takes one word per cycle unless the work queue is full,
// tracks the frame header, and pushes payload, empty-frame and error entries.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wsd_front #(
  parameter int LENGTH_BITS = wsd_pkg::LengthBitsDefault
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [7:0]      stream_byte,
  input  logic            queue_full,
  output logic            push,
  output wsd_pkg::entry_t entry
);
  import wsd_pkg::*;

  localparam logic [2:0] PH_FIRST   = 3'd0;
  localparam logic [2:0] PH_SECOND  = 3'd1;
  localparam logic [2:0] PH_EXTLEN  = 3'd2;
  localparam logic [2:0] PH_KEY     = 3'd3;
  localparam logic [2:0] PH_PAYLOAD = 3'd4;

  localparam logic [LENGTH_BITS-1:0] LenOne  = LENGTH_BITS'(1);
  localparam logic [LENGTH_BITS-1:0] LenZero = '0;

  logic [2:0]             phase, phase_next;
  logic [2:0]             hdr_count, hdr_count_next;
  logic [LENGTH_BITS-1:0] bytes_remaining, bytes_remaining_next;
  logic [31:0]            mask_key, mask_key_next;
  logic [1:0]             mask_pos, mask_pos_next;
  logic                   masked, masked_next;
  logic                   ext_long, ext_long_next;
  logic                   fin, fin_next;
  logic [3:0]             opcode, opcode_next;
  logic                   halted, halted_next;

  logic                   accept;
  logic                   hdr_done;
  logic [LENGTH_BITS-1:0] hdr_len;
  logic [LENGTH_BITS-1:0] len_shift;
  logic [7:0]             key_byte;

  assign in_stall  = queue_full;
  assign accept    = in_valid && !in_stall;
  assign len_shift = {bytes_remaining[LENGTH_BITS-9:0], stream_byte};

  always_comb begin
    case (mask_pos)
      2'd0:    key_byte = mask_key[31:24];
      2'd1:    key_byte = mask_key[23:16];
      2'd2:    key_byte = mask_key[15:8];
      default: key_byte = mask_key[7:0];
    endcase
  end

  always_comb begin
    phase_next           = phase;
    hdr_count_next       = hdr_count;
    bytes_remaining_next = bytes_remaining;
    mask_key_next        = mask_key;
    mask_pos_next        = mask_pos;
    masked_next          = masked;
    ext_long_next        = ext_long;
    fin_next             = fin;
    opcode_next          = opcode;
    halted_next          = halted;
    hdr_done             = 1'b0;
    hdr_len              = bytes_remaining;
    push                 = 1'b0;
    entry                = '0;

    if (accept && !halted) begin
      case (phase)
        PH_FIRST: begin
          if (stream_byte[6:4] != 3'd0) begin
            halted_next = 1'b1;
            push        = 1'b1;
            entry.error = 1'b1;
          end else begin
            fin_next    = stream_byte[7];
            opcode_next = stream_byte[3:0];
            phase_next  = PH_SECOND;
          end
        end
        PH_SECOND: begin
          masked_next    = stream_byte[7];
          hdr_count_next = 3'd0;
          mask_key_next  = '0;
          if (stream_byte[6:0] == LEN_CODE_16 || stream_byte[6:0] == LEN_CODE_64) begin
            ext_long_next        = (stream_byte[6:0] == LEN_CODE_64);
            bytes_remaining_next = '0;
            phase_next           = PH_EXTLEN;
          end else begin
            hdr_len              = {{(LENGTH_BITS-7){1'b0}}, stream_byte[6:0]};
            bytes_remaining_next = hdr_len;
            if (stream_byte[7]) begin
              phase_next = PH_KEY;
            end else begin
              hdr_done = 1'b1;
            end
          end
        end
        PH_EXTLEN: begin
          bytes_remaining_next = len_shift;
          hdr_count_next       = hdr_count + 3'd1;
          if (ext_long ? (hdr_count == 3'd7) : (hdr_count == 3'd1)) begin
            hdr_count_next = 3'd0;
            hdr_len        = len_shift;
            if (masked) begin
              phase_next = PH_KEY;
            end else begin
              hdr_done = 1'b1;
            end
          end
        end
        PH_KEY: begin
          mask_key_next  = {mask_key[23:0], stream_byte};
          hdr_count_next = hdr_count + 3'd1;
          if (hdr_count == 3'd3) begin
            hdr_done = 1'b1;
          end
        end
        PH_PAYLOAD: begin
          push                 = 1'b1;
          entry.data           = stream_byte;
          entry.key            = masked ? key_byte : 8'd0;
          entry.byte_valid     = 1'b1;
          entry.fin            = fin;
          entry.opcode         = opcode;
          entry.frame_end      = (bytes_remaining == LenOne);
          bytes_remaining_next = bytes_remaining - LenOne;
          mask_pos_next        = mask_pos + 2'd1;
          if (bytes_remaining == LenOne) begin
            phase_next = PH_FIRST;
          end
        end
        default: begin
          phase_next = PH_FIRST;
        end
      endcase

      // Header complete: either start the payload or mark an empty frame.
      if (hdr_done) begin
        bytes_remaining_next = hdr_len;
        mask_pos_next        = 2'd0;
        if (hdr_len == LenZero) begin
          phase_next      = PH_FIRST;
          push            = 1'b1;
          entry.frame_end = 1'b1;
          entry.fin       = fin;
          entry.opcode    = opcode;
        end else begin
          phase_next = PH_PAYLOAD;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_FIRST;
      hdr_count       <= 3'd0;
      bytes_remaining <= '0;
      mask_key        <= '0;
      mask_pos        <= 2'd0;
      masked          <= 1'b0;
      ext_long        <= 1'b0;
      fin             <= 1'b0;
      opcode          <= 4'd0;
      halted          <= 1'b0;
    end else begin
      phase           <= phase_next;
      hdr_count       <= hdr_count_next;
      bytes_remaining <= bytes_remaining_next;
      mask_key        <= mask_key_next;
      mask_pos        <= mask_pos_next;
      masked          <= masked_next;
      ext_long        <= ext_long_next;
      fin             <= fin_next;
      opcode          <= opcode_next;
      halted          <= halted_next;
    end
  end

  `WSD_ASSERT_NEVER(a_no_push_halted, clk, rst, halted && push);
  `WSD_ASSERT_IMPLY(a_error_halts, clk, rst, push && entry.error, ##1 halted);

endmodule

@@ sv/wsd_queue.sv @@
// ----------------------------------------------------------------------------
// wsd_queue
// Short register queue that decouples the parser from the output stage.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wsd_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  wsd_pkg::entry_t push_entry,
  output logic            full,
  output logic            not_empty,
  input  logic            pop,
  output wsd_pkg::entry_t head
);
  import wsd_pkg::*;

  entry_t            slots [QueueDepth];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full      = (count == QCNT_W'(QueueDepth));
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  `WSD_ASSERT_NEVER(a_no_overflow, clk, rst, push && full);
  `WSD_ASSERT_NEVER(a_no_underflow, clk, rst, pop && !not_empty);

endmodule

@@ sv/wsd_back.sv @@
// ----------------------------------------------------------------------------
// wsd_back
// Output stage: unmasks queued words and holds each result in a register
// until the consumer takes it.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wsd_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            not_empty,
  input  wsd_pkg::entry_t head,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [7:0]      payload_byte,
  output logic            byte_valid,
  output logic [3:0]      frame_opcode,
  output logic            final_fragment,
  output logic            frame_end,
  output logic            message_end,
  output logic            protocol_error
);
  import wsd_pkg::*;

  assign pop = not_empty && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      payload_byte   <= head.data ^ head.key;
      byte_valid     <= head.byte_valid;
      frame_opcode   <= head.opcode;
      final_fragment <= head.fin;
      frame_end      <= head.frame_end;
      message_end    <= head.frame_end & head.fin;
      protocol_error <= head.error;
    end
  end

  `WSD_ASSERT_IMPLY(a_msg_end_in_frame, clk, rst, out_valid && message_end, frame_end);

endmodule

@@ tb/websocket_frame_deframer_tb.sv @@
// ----------------------------------------------------------------------------
// websocket_frame_deframer_tb
// Drives framed WebSocket byte streams into the deframer and checks every
// output word against a cycle-free software copy of the frame parser. A short
// scripted stream comes first, then randomly built frames under random input
// gaps and output stalls, and the run closes with a reserved-bit halt.
// ----------------------------------------------------------------------------
module websocket_frame_deframer_tb;
  import wsd_pkg::*;

  localparam int RANDOM_WORDS = 700;
  localparam int DRAIN_CYCLES = 20;
  localparam int HOLD_CYCLES  = 80;

  localparam logic [3:0] OP_CONT  = 4'h0;
  localparam logic [3:0] OP_TEXT  = 4'h1;
  localparam logic [3:0] OP_CLOSE = 4'h8;
  localparam logic [3:0] OP_RSVD_F = 4'hF;

  typedef enum logic [2:0] {
    AWAIT_FIRST,
    AWAIT_SECOND,
    EXT_LENGTH,
    MASK_KEY,
    PAYLOAD
  } parse_phase_e;

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic [3:0] opcode;
    logic       fin;
    logic       fend;
    logic       mend;
    logic       err;
  } deframed_word_t;

  typedef struct packed {
    logic [7:0]     b;
    logic           typed;
    deframed_word_t want;
  } script_row_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] stream_byte;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] payload_byte;
  logic       byte_valid;
  logic [3:0] frame_opcode;
  logic       final_fragment;
  logic       frame_end;
  logic       message_end;
  logic       protocol_error;

  websocket_frame_deframer dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .stream_byte    (stream_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .payload_byte   (payload_byte),
    .byte_valid     (byte_valid),
    .frame_opcode   (frame_opcode),
    .final_fragment (final_fragment),
    .frame_end      (frame_end),
    .message_end    (message_end),
    .protocol_error (protocol_error)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Parser copy.
  parse_phase_e phase      = AWAIT_FIRST;
  logic [2:0]   hdr_count  = '0;
  logic [63:0]  frame_len  = '0;
  logic [63:0]  remaining  = '0;
  logic [31:0]  key        = '0;
  logic [1:0]   key_pos    = '0;
  logic         masked     = 1'b0;
  logic         fin        = 1'b0;
  logic [3:0]   opcode     = '0;
  logic         halted     = 1'b0;
  logic [3:0]   ext_needed = '0;

  deframed_word_t pending_words[$];

  int mismatches   = 0;
  int words_sent   = 0;
  int frames_sent  = 0;
  int results_seen = 0;
  int payload_seen = 0;

  // Scripted stream: empty text frame, one-word frame with opcode 15,
  // masked empty frame with a 64-bit zero length, 16-bit length frame.
  script_row_t script [0:24] = '{
    '{8'h81, 1'b0, '0},
    '{8'h00, 1'b1, '{8'h00, 1'b0, OP_TEXT, 1'b1, 1'b1, 1'b1, 1'b0}},
    '{8'h0F, 1'b0, '0},
    '{8'h01, 1'b0, '0},
    '{8'hFF, 1'b1, '{8'hFF, 1'b1, OP_RSVD_F, 1'b0, 1'b1, 1'b0, 1'b0}},
    '{8'h88, 1'b0, '0},
    '{8'hFF, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'hA5, 1'b0, '0},
    '{8'h5A, 1'b0, '0},
    '{8'h3C, 1'b0, '0},
    '{8'hC3, 1'b1, '{8'h00, 1'b0, OP_CLOSE, 1'b1, 1'b1, 1'b1, 1'b0}},
    '{8'h02, 1'b0, '0},
    '{8'h7E, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h02, 1'b0, '0},
    '{8'hAA, 1'b0, '0},
    '{8'h55, 1'b0, '0}
  };

  function automatic deframed_word_t make_word(logic [7:0] data, logic valid,
                                               logic fend, logic err);
    deframed_word_t w;
    w.data   = data;
    w.valid  = valid;
    w.opcode = err ? OP_CONT : opcode;
    w.fin    = err ? 1'b0 : fin;
    w.fend   = fend;
    w.mend   = fend & fin;
    w.err    = err;
    return w;
  endfunction

  // Appends one expected word at the tail of the scoreboard queue.
  function automatic void queue_word(deframed_word_t w);
    pending_words = {pending_words, w};
  endfunction

  task automatic header_complete();
    remaining = frame_len;
    key_pos   = '0;
    if (frame_len == 0) begin
      phase = AWAIT_FIRST;
      queue_word(make_word(8'h00, 1'b0, 1'b1, 1'b0));
    end else begin
      phase = PAYLOAD;
    end
  endtask

  task automatic length_complete();
    hdr_count = '0;
    if (masked)
      phase = MASK_KEY;
    else
      header_complete();
  endtask

  // Advances the parser copy by one stream word and queues any output word.
  task automatic deframe_byte(input logic [7:0] b);
    logic [7:0] kb;
    if (halted)
      return;
    case (phase)
      AWAIT_FIRST: begin
        if (b[6:4] != 3'b000) begin
          halted = 1'b1;
          queue_word(make_word(8'h00, 1'b0, 1'b0, 1'b1));
        end else begin
          fin    = b[7];
          opcode = b[3:0];
          phase  = AWAIT_SECOND;
        end
      end
      AWAIT_SECOND: begin
        masked    = b[7];
        hdr_count = '0;
        key       = '0;
        if (b[6:0] == LEN_CODE_16 || b[6:0] == LEN_CODE_64) begin
          ext_needed = (b[6:0] == LEN_CODE_16) ? 4'd2 : 4'd8;
          frame_len  = '0;
          phase      = EXT_LENGTH;
        end else begin
          frame_len = 64'(b[6:0]);
          length_complete();
        end
      end
      EXT_LENGTH: begin
        frame_len = {frame_len[55:0], b};
        hdr_count = hdr_count + 3'd1;
        // An 8-word length wraps the 3-bit count back to zero.
        if (hdr_count == 0 || 4'(hdr_count) >= ext_needed)
          length_complete();
      end
      MASK_KEY: begin
        key       = {key[23:0], b};
        hdr_count = hdr_count + 3'd1;
        if (hdr_count >= 3'd4)
          header_complete();
      end
      PAYLOAD: begin
        kb        = masked ? key[8 * (3 - key_pos) +: 8] : 8'h00;
        key_pos   = key_pos + 2'd1;
        remaining = remaining - 64'd1;
        queue_word(make_word(b ^ kb, 1'b1, remaining == 0, 1'b0));
        if (remaining == 0)
          phase = AWAIT_FIRST;
      end
      default: phase = AWAIT_FIRST;
    endcase
  endtask

  // Offers one word and waits for it to be taken. Called just after a
  // falling edge; returns just after the falling edge that follows acceptance.
  task automatic feed_word(input logic [7:0] b, input logic typed = 1'b0,
                           input deframed_word_t want = '0);
    bit calm;
    int queued;
    calm = (words_sent >= 300 && words_sent < 450);
    while (!calm && $urandom_range(99) < 19) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid    = 1'b1;
    stream_byte = b;
    do
      @(posedge clk);
    while (in_stall);
    queued = pending_words.size();
    deframe_byte(b);
    if (typed) begin
      if (pending_words.size() > queued)
        void'(pending_words.pop_back());
      queue_word(want);
    end
    words_sent++;
    @(negedge clk);
  endtask

  task automatic send_frame();
    int          pick;
    int          len;
    logic [6:0]  code;
    logic [63:0] len_word;
    logic        mask_on;
    pick = $urandom_range(99);
    if (pick < 70) begin
      len  = $urandom_range(12);
      code = 7'(len);
    end else if (pick < 78) begin
      len  = $urandom_range(125, 13);
      code = 7'(len);
    end else if (pick < 90) begin
      len  = ($urandom_range(5) == 0) ? 0 : $urandom_range(150);
      code = LEN_CODE_16;
    end else begin
      len  = $urandom_range(40);
      code = LEN_CODE_64;
    end
    len_word = 64'(len);
    mask_on  = ($urandom_range(99) < 60);
    feed_word({1'($urandom_range(1)), 3'b000, 4'($urandom_range(15))});
    feed_word({mask_on, code});
    if (code == LEN_CODE_16) begin
      feed_word(len_word[15:8]);
      feed_word(len_word[7:0]);
    end else if (code == LEN_CODE_64) begin
      for (int i = 7; i >= 0; i--)
        feed_word(len_word[8 * i +: 8]);
    end
    if (mask_on)
      repeat (4) feed_word(8'($urandom_range(255)));
    repeat (len) feed_word(8'($urandom_range(255)));
    frames_sent++;
  endtask

  // Receiver: random stalls, one long hold-off to back the block up, and a
  // quiet stretch with no stalls.
  initial begin
    bit hold_done;
    int hold_left;
    hold_done = 1'b0;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_done && results_seen >= 150) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall = 1'b1;
        hold_left--;
      end else begin
        out_stall = !(results_seen >= 250 && results_seen < 400) &&
                    ($urandom_range(99) < 19);
      end
    end
  end

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected %h, got %h", $time, name, want, got);
    end
  endfunction

  // Words are captured at a rising edge and compared only after the falling edge,
  // so the expectation queued at that rising edge is already in place.
  initial begin
    deframed_word_t got;
    deframed_word_t want;
    bit             took;
    forever begin
      @(posedge clk);
      took = out_valid && !out_stall;
      if (took) begin
        got = '{payload_byte, byte_valid, frame_opcode, final_fragment,
                frame_end, message_end, protocol_error};
        results_seen++;
        if (byte_valid === 1'b1)
          payload_seen++;
      end
      @(negedge clk);
      if (took) begin
        if (pending_words.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected output word, expected none, got %h", $time, got);
        end else begin
          want = pending_words.pop_front();
          check_field("payload_byte", want.data, got.data);
          check_field("byte_valid", 8'(want.valid), 8'(got.valid));
          check_field("frame_opcode", 8'(want.opcode), 8'(got.opcode));
          check_field("final_fragment", 8'(want.fin), 8'(got.fin));
          check_field("frame_end", 8'(want.fend), 8'(got.fend));
          check_field("message_end", 8'(want.mend), 8'(got.mend));
          check_field("protocol_error", 8'(want.err), 8'(got.err));
        end
      end
    end
  end

  initial begin
    rst         = 1'b1;
    in_valid    = 1'b0;
    stream_byte = 8'h00;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (script[i])
      feed_word(script[i].b, script[i].typed, script[i].want);

    while (words_sent < $size(script) + RANDOM_WORDS)
      send_frame();

    // Reserved bits halt the parser for good, so this closes the stream;
    // the words after it must vanish without a trace.
    feed_word({1'b1, 3'b111, OP_TEXT});
    repeat (4) feed_word(8'($urandom_range(255)));
    in_valid = 1'b0;

    while (pending_words.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (pending_words.size() != 0) begin
      mismatches++;
      $display("%0t: %0d expected words never arrived", $time, pending_words.size());
    end
    $display("Fed %0d stream words in %0d random frames plus a scripted stream.",
             words_sent, frames_sent);
    $display("Checked %0d output words (%0d payload), closing on a reserved-bit halt.",
             results_seen, payload_seen);
    if (mismatches == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #400000;
    $display("Timed out with %0d words still expected.", pending_words.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
